// ===== rtl/core/sed_pkg.sv =====
// Shared types, constants and kernel arithmetic for the scan-line edgel detector.
`timescale 1ns / 1ps

package sed_pkg;

	localparam int COORD_BITS = 12;
	localparam int POS_W      = 12;
	localparam int CHAN_W     = 8;
	localparam int RESP_W     = 12;
	localparam int SUM_W      = 11;
	localparam int CNT_W      = 3;

	typedef logic [CHAN_W-1:0]     chan_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [RESP_W-1:0]     resp_t;
	typedef logic [RESP_W-1:0]     thresh_t;
	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [SUM_W-1:0]      sum_t;

	localparam thresh_t THRESH_RESET = thresh_t'(256);
	localparam cnt_t    WIN_FULL     = cnt_t'(4);

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} coord_pair_t;

	// control for one request in the working stage
	typedef struct packed {
		logic valid;
		logic line_start;
	} sed_step_t;

	function automatic coord_t coord_from_pos(input pos_t p);
		logic [COORD_BITS+POS_W-1:0] tmp;
		tmp = {{COORD_BITS{1'b0}}, p};
		return tmp[COORD_BITS-1:0];
	endfunction

	function automatic pos_t pos_from_coord(input coord_t c);
		logic [COORD_BITS+POS_W-1:0] tmp;
		tmp = {{POS_W{1'b0}}, c};
		return tmp[POS_W-1:0];
	endfunction

	// |3*cur + 5*w0 - 5*w2 - 3*w3| for one channel
	function automatic resp_t tap_mag(input chan_t cur, input chan_t w0,
			input chan_t w2, input chan_t w3);
		sum_t pos;
		sum_t neg;
		sum_t diff;
		pos  = sum_t'(w0) * sum_t'(5) + sum_t'(cur) * sum_t'(3);
		neg  = sum_t'(w2) * sum_t'(5) + sum_t'(w3) * sum_t'(3);
		diff = (pos >= neg) ? (pos - neg) : (neg - pos);
		return resp_t'(diff);
	endfunction

endpackage

// ===== rtl/core/sed_pixel_if.sv =====
// Pixel request channel: valid/ready with RGB, line start and coordinates.
`timescale 1ns / 1ps

interface sed_pixel_if;
	logic          valid;
	logic          ready;
	logic [7:0]    red;
	logic [7:0]    green;
	logic [7:0]    blue;
	logic          line_start;
	logic [11:0]   pos_x;
	logic [11:0]   pos_y;

	modport source (
		output valid, red, green, blue, line_start, pos_x, pos_y,
		input  ready
	);

	modport sink (
		input  valid, red, green, blue, line_start, pos_x, pos_y,
		output ready
	);
endinterface

// ===== rtl/core/sed_edgel_if.sv =====
// Edgel request channel: valid/ready with peak coordinates and strength.
`timescale 1ns / 1ps

interface sed_edgel_if;
	logic          valid;
	logic          ready;
	logic [11:0]   edgel_x;
	logic [11:0]   edgel_y;
	logic [11:0]   strength;

	modport source (
		output valid, edgel_x, edgel_y, strength,
		input  ready
	);

	modport sink (
		input  valid, edgel_x, edgel_y, strength,
		output ready
	);
endinterface

// ===== rtl/core/sed_window.sv =====
// Four-sample pixel window and per-line sample count.
`timescale 1ns / 1ps

module sed_window (
	input  logic              clk,
	input  logic              arst_n,
	input  sed_pkg::sed_step_t step,
	input  sed_pkg::rgb_t     cur,
	output sed_pkg::rgb_t     tap0,
	output sed_pkg::rgb_t     tap2,
	output sed_pkg::rgb_t     tap3,
	output logic              full
);
	import sed_pkg::*;

	rgb_t win_q [4];
	cnt_t cnt_q;

	assign tap0 = win_q[0];
	assign tap2 = win_q[2];
	assign tap3 = win_q[3];
	// a line start empties the window before this sample is used
	assign full = !step.line_start && (cnt_q >= WIN_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) win_q[i] <= '0;
			cnt_q <= '0;
		end else if (step.valid) begin
			win_q[0] <= cur;
			if (step.line_start) begin
				win_q[1] <= '0;
				win_q[2] <= '0;
				win_q[3] <= '0;
				cnt_q    <= cnt_t'(1);
			end else begin
				win_q[1] <= win_q[0];
				win_q[2] <= win_q[1];
				win_q[3] <= win_q[2];
				if (cnt_q < WIN_FULL) cnt_q <= cnt_q + cnt_t'(1);
			end
		end
	end
endmodule

// ===== rtl/core/sed_kernel.sv =====
// Per-channel kernel magnitudes and threshold gating of the red response.
`timescale 1ns / 1ps

module sed_kernel (
	input  sed_pkg::rgb_t    cur,
	input  sed_pkg::rgb_t    tap0,
	input  sed_pkg::rgb_t    tap2,
	input  sed_pkg::rgb_t    tap3,
	input  logic             full,
	input  sed_pkg::thresh_t thresh,
	output sed_pkg::resp_t   resp
);
	import sed_pkg::*;

	resp_t r_mag;
	resp_t g_mag;
	resp_t b_mag;

	assign r_mag = tap_mag(cur.red,   tap0.red,   tap2.red,   tap3.red);
	assign g_mag = tap_mag(cur.green, tap0.green, tap2.green, tap3.green);
	assign b_mag = tap_mag(cur.blue,  tap0.blue,  tap2.blue,  tap3.blue);

	assign resp = (full && r_mag > thresh && g_mag > thresh && b_mag > thresh)
		? r_mag : '0;
endmodule

// ===== rtl/core/sed_peak.sv =====
// Response history, coordinate delay, peak test and edgel output register.
`timescale 1ns / 1ps

module sed_peak (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sed_pkg::sed_step_t    step,
	input  sed_pkg::resp_t        resp,
	input  sed_pkg::coord_pair_t  coord,
	output logic                  advance,
	sed_edgel_if.source           edgel
);
	import sed_pkg::*;

	resp_t       prev1_q;
	resp_t       prev2_q;
	coord_pair_t cdly_q [3];
	logic        out_valid_q;
	pos_t        out_x_q;
	pos_t        out_y_q;
	resp_t       out_str_q;

	resp_t p1;
	resp_t p2;
	logic  emit;
	logic  out_free;

	assign p1       = step.line_start ? '0 : prev1_q;
	assign p2       = step.line_start ? '0 : prev2_q;
	assign emit     = step.valid && (p1 != '0) && (p1 > p2) && (p1 > resp);
	assign out_free = !out_valid_q || edgel.ready;
	// hold the stage only when it has an edgel and the output is full
	assign advance  = step.valid && (out_free || !emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev1_q <= '0;
			prev2_q <= '0;
			for (int i = 0; i < 3; i++) cdly_q[i] <= '0;
		end else if (advance) begin
			prev2_q   <= p1;
			prev1_q   <= resp;
			cdly_q[0] <= coord;
			cdly_q[1] <= step.line_start ? '0 : cdly_q[0];
			cdly_q[2] <= step.line_start ? '0 : cdly_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (edgel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_x_q   <= pos_from_coord(cdly_q[2].x);
			out_y_q   <= pos_from_coord(cdly_q[2].y);
			out_str_q <= p1;
		end
	end

	assign edgel.valid    = out_valid_q;
	assign edgel.edgel_x  = out_x_q;
	assign edgel.edgel_y  = out_y_q;
	assign edgel.strength = out_str_q;
endmodule

// ===== rtl/core/scanline_edgel_detector.sv =====
// Top level of the scan-line edgel detector.
//
//  channel  | dir | handshake          | payload
//  pix      | in  | valid/ready        | red, green, blue, line_start, pos_x, pos_y
//  edgel    | out | valid/ready        | edgel_x, edgel_y, strength
//  cfg      | in  | cfg_wr_en          | cfg_wr_data (edge threshold)
//
// One pixel per clock while the input stage is not held. A pixel is captured
// in the input register, worked through window, kernel and peak test, and an
// edgel for the peak three samples back lands in the output register.
// Reset clears window, history and count; the threshold resets to 256.
// A full output register stalls the input stage only when the stage holds a
// new edgel; pixels without a result keep flowing.
`timescale 1ns / 1ps

module scanline_edgel_detector (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  sed_pkg::thresh_t cfg_wr_data,
	sed_pixel_if.sink        pix,
	sed_edgel_if.source      edgel
);
	import sed_pkg::*;

	logic        valid_s1;
	rgb_t        rgb_s1;
	logic        line_start_s1;
	coord_pair_t coord_s1;
	thresh_t     thresh_q;

	sed_step_t   step;
	sed_step_t   win_step;
	logic        advance;
	rgb_t        tap0;
	rgb_t        tap2;
	rgb_t        tap3;
	logic        win_full;
	resp_t       resp;

	assign pix.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			rgb_s1        <= '{red: pix.red, green: pix.green, blue: pix.blue};
			line_start_s1 <= pix.line_start;
			coord_s1      <= '{x: coord_from_pos(pix.pos_x), y: coord_from_pos(pix.pos_y)};
		end
	end

	assign step     = '{valid: valid_s1, line_start: line_start_s1};
	assign win_step = '{valid: advance, line_start: line_start_s1};

	sed_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (win_step),
		.cur    (rgb_s1),
		.tap0   (tap0),
		.tap2   (tap2),
		.tap3   (tap3),
		.full   (win_full)
	);

	sed_kernel u_kernel (
		.cur    (rgb_s1),
		.tap0   (tap0),
		.tap2   (tap2),
		.tap3   (tap3),
		.full   (win_full),
		.thresh (thresh_q),
		.resp   (resp)
	);

	sed_peak u_peak (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.resp    (resp),
		.coord   (coord_s1),
		.advance (advance),
		.edgel   (edgel)
	);

`ifndef SYNTHESIS
	a_strength_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		edgel.valid |-> edgel.strength != '0)
		else $error("edgel with zero strength");

	a_resp_needs_window: assert property (@(posedge clk) disable iff (!arst_n)
		resp != '0 |-> win_full)
		else $error("response from a partial window");

	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!edgel.valid |-> pix.ready)
		else $error("input stalled with empty output");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(coord_s1) && $stable(rgb_s1))
		else $error("stalled stage lost its pixel");
`endif
endmodule
